@@ src/lattice_phi4_action_engine_defines.svh @@
// Assertion macros used by the assertions in the top-level engine
`ifndef LATTICE_PHI4_ACTION_ENGINE_DEFINES_SVH
`define LATTICE_PHI4_ACTION_ENGINE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent
`define LPAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence must hold in the cycle after the antecedent
`define LPAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lpae_pkg.sv @@
`default_nettype none
package lpae_pkg;

  localparam int MAX_TIME   = 64;
  localparam int MAX_SPACE  = 64;
  localparam int TIME_W     = $clog2(MAX_TIME);
  localparam int SPACE_W    = $clog2(MAX_SPACE);
  localparam int ADDR_W     = TIME_W + SPACE_W;
  localparam int EXT_W      = 7;
  localparam int VAL_W      = 18;
  localparam int COEF_W     = 18;
  localparam int ACC_W      = 128;
  localparam int MA_W       = 57;
  localparam int MB_W       = 24;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int QDEPTH     = 2;
  localparam int QCNT_W     = 2;
  localparam int STEP_W     = 4;
  localparam int LAST_STEP  = 8;
  localparam int SLOTS      = 5;
  localparam int RD_W       = 3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_LOCAL = 2'd1,
    KIND_TOTAL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MASS     = 2'd0,
    CFG_COUPLING = 2'd1,
    CFG_TIME     = 2'd2,
    CFG_SPACE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MUL,
    B_FIN
  } back_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SET_D,
    OP_SET_Q,
    OP_ADD_Q,
    OP_SET_CD,
    OP_ACC0,
    OP_ACC19,
    OP_ACC24,
    OP_ACC37,
    OP_ACC38
  } op_t;

  typedef struct packed {
    kind_t                    kind;
    logic [TIME_W-1:0]        t;
    logic [SPACE_W-1:0]       x;
    logic signed [VAL_W-1:0]  v;
  } item_t;

  typedef struct packed {
    logic [COEF_W-1:0] mass;
    logic [COEF_W-1:0] coup;
    logic [EXT_W-1:0]  nt;
    logic [EXT_W-1:0]  nx;
  } cfg_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // Limit an extent to the range three to the lattice maximum
  function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e,
                                                 input logic [EXT_W-1:0] m);
    logic [EXT_W-1:0] r;
    r = e;
    if (e < EXT_W'(3)) r = EXT_W'(3);
    else if (e > m)    r = m;
    return r;
  endfunction

  // Periodic step forward by d
  function automatic logic [EXT_W-1:0] wrap_add(input logic [EXT_W-1:0] i,
                                                input logic [1:0] d,
                                                input logic [EXT_W-1:0] n);
    logic [EXT_W-1:0] s;
    s = i + EXT_W'(d);
    if (s >= n) s = s - n;
    return s;
  endfunction

  // Periodic step back by d
  function automatic logic [EXT_W-1:0] wrap_sub(input logic [EXT_W-1:0] i,
                                                input logic [1:0] d,
                                                input logic [EXT_W-1:0] n);
    logic [EXT_W-1:0] s;
    if (i >= EXT_W'(d)) s = i - EXT_W'(d);
    else                s = i + n - EXT_W'(d);
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/lpae_front.sv @@
`default_nettype none
module lpae_front import lpae_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     block,
  input  logic [1:0]               kind,
  input  logic [TIME_W-1:0]        time_index,
  input  logic [SPACE_W-1:0]       space_index,
  input  logic signed [VAL_W-1:0]  value,
  input  cfg_t                     cfg,
  input  logic                     q_full,
  output logic                     held,
  output logic                     push,
  output item_t                    item
);

  logic accept;
  logic t_over;
  logic x_over;

  assign accept = start && !held && !block;
  assign t_over = {1'b0, item.t} >= cfg.nt;
  assign x_over = {1'b0, item.x} >= cfg.nx;
  assign push   = held && !t_over && !x_over && !q_full;

  // Hold one item; drop unused kinds at the door
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= (kind_t'(kind) != KIND_NONE);
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Reduce coordinates into the extents in use, one subtraction a cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= '{kind: kind_t'(kind), t: time_index, x: space_index, v: value};
    end else if (held) begin
      if (t_over) item.t <= item.t - cfg.nt[TIME_W-1:0];
      if (x_over) item.x <= item.x - cfg.nx[SPACE_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ src/lpae_queue.sv @@
`default_nettype none
module lpae_queue import lpae_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t status
);

  item_t             slot [QDEPTH];
  logic [QCNT_W-1:0] count;

  assign head         = slot[0];
  assign status.count = count;
  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);

  // Track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Shift on pop, write behind the last live entry; a push never meets a full queue,
  // so a push with a pop only happens with one entry live
  always_ff @(posedge clk) begin
    if (pop) begin
      slot[0] <= push ? push_item : slot[1];
    end else if (push) begin
      if (count == '0) slot[0] <= push_item;
      else             slot[1] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ src/lpae_back.sv @@
`default_nettype none
module lpae_back import lpae_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  item_t               q_item,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic signed [63:0]  amount,
  output logic                saturated
);

  logic [VAL_W-1:0] mem [MAX_TIME*MAX_SPACE];
  logic [VAL_W-1:0] mem_q;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  back_state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [RD_W-1:0]   rd_idx;
  logic [STEP_W-1:0] step;
  logic              is_total;
  logic [TIME_W-1:0]  cur_t;
  logic [SPACE_W-1:0] cur_x;
  logic signed [VAL_W-1:0] eta;
  logic signed [VAL_W-1:0] s [SLOTS];
  logic signed [37:0] d;
  logic [37:0]        q;
  logic signed [55:0] cd;
  logic signed [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  op_t prod_op;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  op_t issue_op;
  logic [1:0] hop;
  logic [EXT_W-1:0] rt;
  logic [EXT_W-1:0] rx;
  logic last_site;
  logic start_query;

  logic signed [19:0] s_sum;
  logic signed [18:0] n_val;
  logic signed [19:0] two_p_v;
  logic signed [23:0] kin_b;
  logic signed [18:0] dt;
  logic signed [18:0] dx;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] sh;
  logic fits;

  assign clearing    = (state == B_CLEAR);
  assign hop         = is_total ? 2'd1 : 2'd2;
  assign last_site   = ({1'b0, cur_t} == cfg.nt - 1'b1) && ({1'b0, cur_x} == cfg.nx - 1'b1);
  assign start_query = (state == B_IDLE) && !q_empty &&
                       (q_item.kind == KIND_LOCAL || q_item.kind == KIND_TOTAL);

  // Site memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == '1) state_next = B_IDLE;
      B_IDLE:  if (start_query) state_next = B_READ;
      B_READ:  if (rd_idx == RD_W'(SLOTS)) state_next = B_MUL;
      B_MUL: begin
        if (step == STEP_W'(LAST_STEP)) state_next = (is_total && !last_site) ? B_READ : B_FIN;
      end
      B_FIN:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Memory port and queue control
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {q_item.t, q_item.x};
    mem_wdata = q_item.v;
    rt        = {1'b0, cur_t};
    rx        = {1'b0, cur_x};
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      B_IDLE: begin
        pop    = !q_empty;
        mem_we = !q_empty && (q_item.kind == KIND_WRITE);
      end
      B_READ: begin
        unique case (rd_idx)
          3'd1:    rx = wrap_add({1'b0, cur_x}, hop, cfg.nx);
          3'd2:    rx = wrap_sub({1'b0, cur_x}, hop, cfg.nx);
          3'd3:    rt = wrap_add({1'b0, cur_t}, hop, cfg.nt);
          3'd4:    rt = wrap_sub({1'b0, cur_t}, hop, cfg.nt);
          default: ;
        endcase
      end
      default: ;
    endcase
    mem_raddr = {rt[TIME_W-1:0], rx[SPACE_W-1:0]};
  end

  // Operand preparation
  assign s_sum   = 20'(s[1]) + 20'(s[2]) + 20'(s[3]) + 20'(s[4]);
  assign n_val   = 19'(s[0]) + 19'(eta);
  assign two_p_v = 20'(s[0]) + 20'(s[0]) + 20'(eta);
  assign kin_b   = (24'(eta) <<< 1) + (24'(s[0]) <<< 2) - 24'(s_sum);
  assign dt      = 19'(s[3]) - 19'(s[4]);
  assign dx      = 19'(s[1]) - 19'(s[2]);

  // Multiplier schedule for one site
  always_comb begin
    ma       = '0;
    mb       = '0;
    issue_op = OP_NONE;
    if (state == B_MUL) begin
      if (!is_total) begin
        unique case (step)
          4'd0: begin ma = MA_W'(eta); mb = MB_W'(two_p_v); issue_op = OP_SET_D; end
          4'd1: begin ma = MA_W'(n_val); mb = MB_W'(n_val); issue_op = OP_SET_Q; end
          4'd2: begin ma = MA_W'(s[0]); mb = MB_W'(s[0]); issue_op = OP_ADD_Q; end
          4'd3: begin ma = MA_W'(eta); mb = kin_b; issue_op = OP_ACC38; end
          4'd4: begin ma = MA_W'(d); mb = $signed({6'd0, cfg.coup}); issue_op = OP_SET_CD; end
          4'd5: begin ma = MA_W'(d); mb = $signed({6'd0, cfg.mass}); issue_op = OP_ACC24; end
          4'd6: begin ma = MA_W'(cd); mb = $signed({5'd0, q[18:0]}); issue_op = OP_ACC0; end
          4'd7: begin ma = MA_W'(cd); mb = $signed({5'd0, q[37:19]}); issue_op = OP_ACC19; end
          default: ;
        endcase
      end else begin
        unique case (step)
          4'd0: begin ma = MA_W'(s[0]); mb = MB_W'(s[0]); issue_op = OP_SET_Q; end
          4'd1: begin ma = MA_W'(dt); mb = MB_W'(dt); issue_op = OP_ACC37; end
          4'd2: begin ma = MA_W'(dx); mb = MB_W'(dx); issue_op = OP_ACC37; end
          4'd3: begin
            ma = $signed({19'd0, q}); mb = $signed({6'd0, cfg.mass}); issue_op = OP_ACC24;
          end
          4'd4: begin
            ma = $signed({19'd0, q}); mb = $signed({6'd0, cfg.coup}); issue_op = OP_SET_CD;
          end
          4'd6: begin ma = MA_W'(cd); mb = $signed({5'd0, q[18:0]}); issue_op = OP_ACC0; end
          4'd7: begin ma = MA_W'(cd); mb = $signed({5'd0, q[37:19]}); issue_op = OP_ACC19; end
          default: ;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      rd_idx   <= '0;
      step     <= '0;
      prod_op  <= OP_NONE;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clearing ? clr_addr + 1'b1 : '0;
      rd_idx   <= (state == B_READ) ? rd_idx + 1'b1 : '0;
      step     <= (state == B_MUL) ? step + 1'b1 : '0;
      prod_op  <= issue_op;
      done     <= (state == B_FIN);
    end
  end

  // Latch the query and walk the lattice for a total
  always_ff @(posedge clk) begin
    if (start_query) begin
      is_total <= (q_item.kind == KIND_TOTAL);
      eta      <= q_item.v;
      cur_t    <= (q_item.kind == KIND_TOTAL) ? '0 : q_item.t;
      cur_x    <= (q_item.kind == KIND_TOTAL) ? '0 : q_item.x;
    end else if (state == B_MUL && step == STEP_W'(LAST_STEP) && is_total && !last_site) begin
      if ({1'b0, cur_x} == cfg.nx - 1'b1) begin
        cur_x <= '0;
        cur_t <= cur_t + 1'b1;
      end else begin
        cur_x <= cur_x + 1'b1;
      end
    end
  end

  // Capture read data in the cycle after its address
  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      unique case (rd_idx)
        3'd1:    s[0] <= mem_q;
        3'd2:    s[1] <= mem_q;
        3'd3:    s[2] <= mem_q;
        3'd4:    s[3] <= mem_q;
        3'd5:    s[4] <= mem_q;
        default: ;
      endcase
    end
  end

  // Registered product, then fold it into its destination
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (start_query) acc <= '0;
    unique case (prod_op)
      OP_SET_D:  d   <= prod[37:0];
      OP_SET_Q:  q   <= prod[37:0];
      OP_ADD_Q:  q   <= q + prod[37:0];
      OP_SET_CD: cd  <= prod[55:0];
      OP_ACC0:   acc <= acc + ACC_W'(prod);
      OP_ACC19:  acc <= acc + (ACC_W'(prod) <<< 19);
      OP_ACC24:  acc <= acc + (ACC_W'(prod) <<< 24);
      OP_ACC37:  acc <= acc + (ACC_W'(prod) <<< 37);
      OP_ACC38:  acc <= acc + (ACC_W'(prod) <<< 38);
      default:   ;
    endcase
  end

  // Round to Q39.24 and clip
  assign rnd  = acc + (ACC_W'(1) <<< 39);
  assign sh   = rnd >>> 40;
  assign fits = (&sh[ACC_W-1:63]) || !(|sh[ACC_W-1:63]);

  always_ff @(posedge clk) begin
    if (state == B_FIN) begin
      saturated <= !fits;
      if (fits)            amount <= sh[63:0];
      else if (rnd[ACC_W-1]) amount <= {1'b1, 63'd0};
      else                 amount <= {1'b0, {63{1'b1}}};
    end
  end

endmodule
`default_nettype wire

@@ src/lattice_phi4_action_engine.sv @@
// Lattice phi^4 action engine.
// Input: an item is transferred at a clock edge with start high and busy low.
//   kind 0 writes value at (time_index, space_index); kind 1 returns the
//   action change from shifting that site by value; kind 2 returns the total
//   action over the lattice in use; kind 3 is dropped.
// Output: done is high for one cycle with amount and saturated; the receiver
//   cannot stall, so each result is shown exactly once.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
//   the user must write only while no item is in flight, a rule the block leaves unchecked.
// Timing: the front reduces coordinates one subtraction a cycle, and a
//   two-entry queue feeds the back. A write is stored from the queue head
//   while the back is idle. A local query reads five sites through the
//   memory port, runs the multiplier schedule and then rounds the result. A
//   total query does the reads and multiplies for each site in turn, through
//   the single memory read port and the shared multiplier.
// Reset: registers return to their reset values and the site memory is
//   cleared one site a cycle; busy stays high until the clear is done.
`default_nettype none
module lattice_phi4_action_engine import lpae_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic [TIME_W-1:0]        time_index,
  input  logic [SPACE_W-1:0]       space_index,
  input  logic signed [VAL_W-1:0]  value,
  output logic                     done,
  output logic signed [63:0]       amount,
  output logic                     saturated,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

`include "lattice_phi4_action_engine_defines.svh"

  logic [COEF_W-1:0] mass_coeff;
  logic [COEF_W-1:0] coupling_coeff;
  logic [EXT_W-1:0]  time_extent;
  logic [EXT_W-1:0]  space_extent;
  cfg_t      cfg;
  logic      held;
  logic      push;
  item_t     front_item;
  item_t     head;
  q_status_t q_status;
  logic      pop;
  logic      clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_coeff     <= '0;
      coupling_coeff <= '0;
      time_extent    <= EXT_W'(64);
      space_extent   <= EXT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASS:     mass_coeff     <= cfg_data;
        CFG_COUPLING: coupling_coeff <= cfg_data;
        CFG_TIME:     time_extent    <= cfg_data[EXT_W-1:0];
        CFG_SPACE:    space_extent   <= cfg_data[EXT_W-1:0];
        default:      ;
      endcase
    end
  end

  assign cfg.mass = mass_coeff;
  assign cfg.coup = coupling_coeff;
  assign cfg.nt   = clamp_ext(time_extent, EXT_W'(MAX_TIME));
  assign cfg.nx   = clamp_ext(space_extent, EXT_W'(MAX_SPACE));
  assign busy     = held || clearing;

  lpae_front u_front (
    .clk(clk), .rst(rst), .start(start), .block(clearing), .kind(kind),
    .time_index(time_index), .space_index(space_index), .value(value),
    .cfg(cfg), .q_full(q_status.full), .held(held), .push(push), .item(front_item)
  );

  lpae_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(front_item), .pop(pop),
    .head(head), .status(q_status)
  );

  lpae_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_status.empty), .q_item(head),
    .pop(pop), .clearing(clearing), .done(done), .amount(amount),
    .saturated(saturated)
  );

  `LPAE_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
  `LPAE_ASSERT_NOW(a_sat_rail, done && saturated, amount == 64'sh8000000000000000 || amount == 64'sh7fffffffffffffff, "saturated result not at a rail")
  `LPAE_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= QCNT_W'(QDEPTH), "queue over its depth")
  `LPAE_ASSERT_NOW(a_quiet_clear, clearing, !done && !pop, "activity during memory clear")

endmodule
`default_nettype wire
